[hw/rtl/ubhs_pkg.sv]
// Package for the UART bootloader host sequencer: phase, operation and command
// codes, result and configuration structs, protocol bytes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package ubhs_pkg;

	localparam int CHUNK_BYTES_DEF = 256;

	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
	localparam logic [15:0] ID_TIMEOUT_RST  = 16'd500;
	localparam logic [31:0] FLASH_BASE_RST  = 32'h0800_0000;

	// Bytes exchanged with the target bootloader.
	localparam logic [7:0] BYTE_ACK      = 8'h79;
	localparam logic [7:0] BYTE_NACK     = 8'h1F;
	localparam logic [7:0] BYTE_SYNC     = 8'h7F;
	localparam logic [7:0] BYTE_GET_ID   = 8'h02;
	localparam logic [7:0] BYTE_ERASE    = 8'h43;
	localparam logic [7:0] BYTE_WRITE    = 8'h31;
	localparam logic [7:0] BYTE_ERASE_GL = 8'hFF;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;

	// Status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SYNC_FAIL  = 3'd1;
	localparam logic [2:0] ST_ID_ACK     = 3'd2;
	localparam logic [2:0] ST_ID_COUNT   = 3'd3;
	localparam logic [2:0] ST_ID_BYTES   = 3'd4;
	localparam logic [2:0] ST_ID_END     = 3'd5;
	localparam logic [2:0] ST_ERASE_FAIL = 3'd6;
	localparam logic [2:0] ST_WRITE_FAIL = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_ID_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_FLASH_BASE  = 2'd2;

	typedef enum logic [2:0] {
		CMD_TICK         = 3'd0,
		CMD_TARGET_BYTE  = 3'd1,
		CMD_IDENTIFY     = 3'd2,
		CMD_UPLOAD_START = 3'd3,
		CMD_UPLOAD_DATA  = 3'd4,
		CMD_UPLOAD_END   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_IDENT = 2'd1,
		OP_START = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_SYNC_TX     = 5'd1,
		PH_SYNC_ACK    = 5'd2,
		PH_ID_TX0      = 5'd3,
		PH_ID_TX1      = 5'd4,
		PH_ID_ACK      = 5'd5,
		PH_ID_COUNT    = 5'd6,
		PH_ID_BYTES    = 5'd7,
		PH_ID_END_ACK  = 5'd8,
		PH_ER_TX0      = 5'd9,
		PH_ER_TX1      = 5'd10,
		PH_ER_ACK      = 5'd11,
		PH_ER_ARG0     = 5'd12,
		PH_ER_ARG1     = 5'd13,
		PH_ER_END_ACK  = 5'd14,
		PH_WR_TX0      = 5'd15,
		PH_WR_TX1      = 5'd16,
		PH_WR_ACK      = 5'd17,
		PH_WR_ADDR     = 5'd18,
		PH_WR_ASUM     = 5'd19,
		PH_WR_ADDR_ACK = 5'd20,
		PH_WR_LEN      = 5'd21,
		PH_WR_DATA     = 5'd22,
		PH_WR_DSUM     = 5'd23,
		PH_WR_END_ACK  = 5'd24
	} phase_t;

	typedef struct packed {
		logic [15:0] ack_timeout_ticks;
		logic [15:0] id_timeout_ticks;
		logic [31:0] flash_base_address;
	} cfg_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        done_res;
		logic [2:0]  status;
		logic [15:0] product_id;
		logic        rejected;
	} result_t;

	// Status reported when the wait in a given phase fails.
	function automatic logic [2:0] fail_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_SYNC_ACK:                  code = ST_SYNC_FAIL;
			PH_ID_ACK:                    code = ST_ID_ACK;
			PH_ID_COUNT:                  code = ST_ID_COUNT;
			PH_ID_BYTES:                  code = ST_ID_BYTES;
			PH_ID_END_ACK:                code = ST_ID_END;
			PH_ER_ACK, PH_ER_END_ACK:     code = ST_ERASE_FAIL;
			default:                      code = ST_WRITE_FAIL;
		endcase
		return code;
	endfunction

endpackage

[hw/rtl/ubhs_ifs.sv]
// Valid/ready channel interfaces for the UART bootloader host sequencer.
// Depends on nothing but carries the payload fields of each channel.
`timescale 1ns / 1ps

interface ubhs_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] data;

	modport source (output valid, command, data, input ready);
	modport sink (input valid, command, data, output ready);
endinterface

interface ubhs_result_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        done_res;
	logic [2:0]  status;
	logic [15:0] product_id;
	logic        rejected;

	modport source (output valid, tx_valid, tx_byte, done_res, status, product_id, rejected,
		input ready);
	modport sink (input valid, tx_valid, tx_byte, done_res, status, product_id, rejected,
		output ready);
endinterface

[hw/rtl/uart_bootloader_host_sequencer.sv]
// Host-side UART bootloader sequencer: the top level with the input register,
// the configuration registers and the result register.
// Depends on ubhs_pkg, ubhs_ifs and ubhs_core.
`timescale 1ns / 1ps

// Each transaction on item is a tick, a byte received from the target or a
// command, and causes at most one transaction on result: a byte to send, a
// completion with its status, or a rejection of a command that arrived while
// a sequence was busy. One item is taken every clock cycle while item does not
// stall; an item is held in the input register while the sequencer computes
// its result, and the result register is loaded with it when the sequencer
// steps. The result register decouples the two sides: item stalls only when
// the input register is occupied and the result register still holds a
// result not yet taken. The chunk buffer is a RAM with a registered read,
// addressed ahead of the data byte that needs it, and configuration writes
// take effect on the next clock edge.
module uart_bootloader_host_sequencer import ubhs_pkg::*; #(
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ubhs_item_if.sink     item,
	ubhs_result_if.source result,
	input  logic          cfg_write,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	logic       valid_s1;
	logic [2:0] command_s1;
	logic [7:0] data_s1;
	logic       step;
	cfg_t       cfg_q;
	logic       res_have;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	assign step       = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			command_s1 <= item.command;
			data_s1    <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_timeout_ticks  <= ACK_TIMEOUT_RST;
			cfg_q.id_timeout_ticks   <= ID_TIMEOUT_RST;
			cfg_q.flash_base_address <= FLASH_BASE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks  <= cfg_data[15:0];
				CFG_ID_TIMEOUT:  cfg_q.id_timeout_ticks   <= cfg_data[15:0];
				CFG_FLASH_BASE:  cfg_q.flash_base_address <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ubhs_core #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.command (command_s1),
		.data    (data_s1),
		.cfg     (cfg_q),
		.res_have(res_have),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_have) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_have) begin
			out_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.tx_valid   = out_q.tx_valid;
	assign result.tx_byte    = out_q.tx_byte;
	assign result.done_res   = out_q.done_res;
	assign result.status     = out_q.status;
	assign result.product_id = out_q.product_id;
	assign result.rejected   = out_q.rejected;

endmodule

[hw/rtl/ubhs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the chunk buffer; no dependencies.
`timescale 1ns / 1ps

module ubhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ubhs_core.sv]
// Sequencer state and next-state logic of the UART bootloader host sequencer.
// Depends on ubhs_pkg and ubhs_ram (the chunk buffer).
`timescale 1ns / 1ps

module ubhs_core import ubhs_pkg::*; #(
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [2:0] command,
	input  logic [7:0] data,
	input  cfg_t       cfg,
	output logic       res_have,
	output result_t    res
);

	localparam int CW  = $clog2(CHUNK_BYTES + 1);
	localparam int AW  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
	localparam int SIW = (CW > 3) ? CW : 3;

	phase_t         phase_q, phase_d;
	op_t            operation_q, operation_d;
	logic [SIW-1:0] send_index_q, send_index_d;
	logic [15:0]    wait_ticks_q, wait_ticks_d;
	logic [31:0]    target_address_q, target_address_d;
	logic [7:0]     frame_checksum_q, frame_checksum_d;
	logic [CW-1:0]  buffer_count_q, buffer_count_d;
	logic           upload_ok_q, upload_ok_d;
	logic [15:0]    id_accumulator_q, id_accumulator_d;
	logic [8:0]     id_bytes_left_q, id_bytes_left_d;

	logic           ram_we;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	logic           fin_en;
	logic [2:0]     fin_status;
	logic [15:0]    fin_pid;
	logic           emit_en;
	logic [7:0]     emit_byte;
	phase_t         emit_next;
	logic           fail_en;
	logic [SIW-1:0] si_inc;
	logic [16:0]    wait_inc;
	logic [CW-1:0]  count_inc;
	logic [CW-1:0]  len_m1;
	logic [7:0]     addr_byte;

	// The read address follows the next send index whenever the sequencer steps,
	// so the registered read data always holds the entry at the current send index.
	assign ram_raddr = step ? send_index_d[AW-1:0] : send_index_q[AW-1:0];

	ubhs_ram #(
		.WIDTH(8),
		.DEPTH(CHUNK_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(buffer_count_q[AW-1:0]),
		.wdata(data),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			operation_q      <= OP_NONE;
			send_index_q     <= '0;
			wait_ticks_q     <= '0;
			target_address_q <= FLASH_BASE_RST;
			frame_checksum_q <= '0;
			buffer_count_q   <= '0;
			upload_ok_q      <= 1'b0;
			id_accumulator_q <= '0;
			id_bytes_left_q  <= '0;
		end else if (step) begin
			phase_q          <= phase_d;
			operation_q      <= operation_d;
			send_index_q     <= send_index_d;
			wait_ticks_q     <= wait_ticks_d;
			target_address_q <= target_address_d;
			frame_checksum_q <= frame_checksum_d;
			buffer_count_q   <= buffer_count_d;
			upload_ok_q      <= upload_ok_d;
			id_accumulator_q <= id_accumulator_d;
			id_bytes_left_q  <= id_bytes_left_d;
		end
	end

	assign si_inc    = send_index_q + 1'b1;
	assign wait_inc  = {1'b0, wait_ticks_q} + 17'd1;
	assign count_inc = buffer_count_q + 1'b1;
	assign len_m1    = buffer_count_q - 1'b1;

	always_comb begin
		case (send_index_q[1:0])
			2'd0:    addr_byte = target_address_q[31:24];
			2'd1:    addr_byte = target_address_q[23:16];
			2'd2:    addr_byte = target_address_q[15:8];
			default: addr_byte = target_address_q[7:0];
		endcase
	end

	always_comb begin
		phase_d          = phase_q;
		operation_d      = operation_q;
		send_index_d     = send_index_q;
		wait_ticks_d     = wait_ticks_q;
		target_address_d = target_address_q;
		frame_checksum_d = frame_checksum_q;
		buffer_count_d   = buffer_count_q;
		upload_ok_d      = upload_ok_q;
		id_accumulator_d = id_accumulator_q;
		id_bytes_left_d  = id_bytes_left_q;
		ram_we           = 1'b0;
		fin_en           = 1'b0;
		fin_status       = ST_OK;
		fin_pid          = '0;
		emit_en          = 1'b0;
		emit_byte        = '0;
		emit_next        = phase_q;
		fail_en          = 1'b0;
		res_have         = 1'b0;
		res              = '0;

		if ((command inside {[CMD_IDENTIFY:CMD_UPLOAD_END]}) && phase_q != PH_IDLE) begin
			res_have     = 1'b1;
			res.rejected = 1'b1;
		end else begin
			case (command)
				CMD_TICK: begin
					case (phase_q)
						PH_IDLE: begin
						end
						PH_SYNC_TX: begin
							emit_en = 1'b1; emit_byte = BYTE_SYNC; emit_next = PH_SYNC_ACK;
						end
						PH_ID_TX0: begin
							emit_en = 1'b1; emit_byte = BYTE_GET_ID; emit_next = PH_ID_TX1;
						end
						PH_ID_TX1: begin
							emit_en = 1'b1; emit_byte = ~BYTE_GET_ID; emit_next = PH_ID_ACK;
						end
						PH_ER_TX0: begin
							emit_en = 1'b1; emit_byte = BYTE_ERASE; emit_next = PH_ER_TX1;
						end
						PH_ER_TX1: begin
							emit_en = 1'b1; emit_byte = ~BYTE_ERASE; emit_next = PH_ER_ACK;
						end
						PH_ER_ARG0: begin
							emit_en = 1'b1; emit_byte = BYTE_ERASE_GL; emit_next = PH_ER_ARG1;
						end
						PH_ER_ARG1: begin
							emit_en = 1'b1; emit_byte = BYTE_ZERO; emit_next = PH_ER_END_ACK;
						end
						PH_WR_TX0: begin
							emit_en = 1'b1; emit_byte = BYTE_WRITE; emit_next = PH_WR_TX1;
						end
						PH_WR_TX1: begin
							emit_en = 1'b1; emit_byte = ~BYTE_WRITE; emit_next = PH_WR_ACK;
						end
						PH_WR_ADDR: begin
							emit_en          = 1'b1;
							emit_byte        = addr_byte;
							frame_checksum_d = frame_checksum_q ^ addr_byte;
							send_index_d     = si_inc;
							emit_next        = (si_inc >= SIW'(4)) ? PH_WR_ASUM : PH_WR_ADDR;
						end
						PH_WR_ASUM: begin
							emit_en = 1'b1; emit_byte = frame_checksum_q;
							emit_next = PH_WR_ADDR_ACK;
						end
						PH_WR_LEN: begin
							emit_en          = 1'b1;
							emit_byte        = 8'(len_m1);
							frame_checksum_d = 8'(len_m1);
							send_index_d     = '0;
							emit_next        = PH_WR_DATA;
						end
						PH_WR_DATA: begin
							emit_en          = 1'b1;
							emit_byte        = ram_rdata;
							frame_checksum_d = frame_checksum_q ^ ram_rdata;
							send_index_d     = si_inc;
							emit_next        = (si_inc >= SIW'(buffer_count_q)) ?
								PH_WR_DSUM : PH_WR_DATA;
						end
						PH_WR_DSUM: begin
							emit_en = 1'b1; emit_byte = frame_checksum_q;
							emit_next = PH_WR_END_ACK;
						end
						PH_ID_COUNT, PH_ID_BYTES: begin
							if (wait_inc > {1'b0, cfg.id_timeout_ticks}) begin
								fail_en = 1'b1;
							end else begin
								wait_ticks_d = wait_inc[15:0];
							end
						end
						default: begin
							// Every remaining phase waits for ACK or NACK.
							if (wait_inc >= {1'b0, cfg.ack_timeout_ticks}) begin
								fail_en = 1'b1;
							end else begin
								wait_ticks_d = wait_inc[15:0];
							end
						end
					endcase
				end
				CMD_TARGET_BYTE: begin
					case (phase_q)
						PH_SYNC_ACK, PH_ID_ACK, PH_ID_END_ACK, PH_ER_ACK, PH_ER_END_ACK,
						PH_WR_ACK, PH_WR_ADDR_ACK, PH_WR_END_ACK: begin
							if (data == BYTE_ACK) begin
								case (phase_q)
									PH_SYNC_ACK: begin
										phase_d = (operation_q == OP_IDENT) ? PH_ID_TX0 : PH_ER_TX0;
									end
									PH_ID_ACK: begin
										wait_ticks_d = '0;
										phase_d      = PH_ID_COUNT;
									end
									PH_ID_END_ACK: begin
										fin_en  = 1'b1;
										fin_pid = id_accumulator_q;
									end
									PH_ER_ACK: begin
										phase_d = PH_ER_ARG0;
									end
									PH_ER_END_ACK: begin
										fin_en = 1'b1;
									end
									PH_WR_ACK: begin
										send_index_d     = '0;
										frame_checksum_d = '0;
										phase_d          = PH_WR_ADDR;
									end
									PH_WR_ADDR_ACK: begin
										phase_d = PH_WR_LEN;
									end
									default: begin
										target_address_d = target_address_q + 32'(buffer_count_q);
										buffer_count_d   = '0;
										fin_en           = 1'b1;
									end
								endcase
							end else if (data == BYTE_NACK) begin
								fail_en = 1'b1;
							end
						end
						PH_ID_COUNT: begin
							id_bytes_left_d = {1'b0, data} + 9'd1;
							phase_d         = PH_ID_BYTES;
						end
						PH_ID_BYTES: begin
							id_accumulator_d = {id_accumulator_q[7:0], data};
							id_bytes_left_d  = id_bytes_left_q - 9'd1;
							if (id_bytes_left_q == 9'd1) begin
								wait_ticks_d = '0;
								phase_d      = PH_ID_END_ACK;
							end
						end
						default: begin
						end
					endcase
				end
				CMD_IDENTIFY: begin
					operation_d      = OP_IDENT;
					id_accumulator_d = '0;
					id_bytes_left_d  = '0;
					phase_d          = PH_SYNC_TX;
				end
				CMD_UPLOAD_START: begin
					operation_d      = OP_START;
					upload_ok_d      = 1'b1;
					target_address_d = cfg.flash_base_address;
					buffer_count_d   = '0;
					phase_d          = PH_SYNC_TX;
				end
				CMD_UPLOAD_DATA: begin
					if (upload_ok_q) begin
						ram_we         = step;
						buffer_count_d = count_inc;
						if (count_inc >= CW'(CHUNK_BYTES)) begin
							operation_d = OP_NONE;
							phase_d     = PH_WR_TX0;
						end
					end
				end
				CMD_UPLOAD_END: begin
					operation_d = OP_END;
					if (upload_ok_q && buffer_count_q != '0) begin
						phase_d = PH_WR_TX0;
					end else begin
						fin_en     = 1'b1;
						fin_status = upload_ok_q ? ST_OK : ST_WRITE_FAIL;
					end
				end
				default: begin
				end
			endcase
		end

		if (emit_en) begin
			res_have     = 1'b1;
			res.tx_valid = 1'b1;
			res.tx_byte  = emit_byte;
			wait_ticks_d = '0;
			phase_d      = emit_next;
		end

		if (fail_en) begin
			if (phase_q >= PH_WR_TX0) begin
				buffer_count_d = '0;
			end
			fin_en     = 1'b1;
			fin_status = fail_code(phase_q);
		end

		if (fin_en) begin
			if (fin_status != ST_OK && operation_d != OP_IDENT) begin
				upload_ok_d = 1'b0;
			end
			if (operation_d != OP_NONE) begin
				res_have       = 1'b1;
				res.done_res   = 1'b1;
				res.status     = fin_status;
				res.product_id = (fin_status == ST_OK && operation_d == OP_IDENT) ? fin_pid : '0;
			end
			phase_d     = PH_IDLE;
			operation_d = OP_NONE;
		end
	end

	a_idle_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> operation_q == OP_NONE)
		else $error("sequencer idle with an operation still open");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buffer_count_q <= CW'(CHUNK_BYTES))
		else $error("chunk buffer count beyond capacity");

	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_have && res.done_res |=> phase_q == PH_IDLE)
		else $error("sequence reported done but did not return to idle");

	a_pid_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_have && res.product_id != '0 |-> res.done_res && res.status == ST_OK)
		else $error("product id reported outside a successful identify");

endmodule

[test/uart_bootloader_host_sequencer_tb.sv]
// Self-checking testbench for uart_bootloader_host_sequencer: it plays the target bootloader
// and the host, predicts every result transaction and compares it field by field.
// Depends on ubhs_pkg, the ubhs_ifs channel interfaces and the sequencer RTL.
`timescale 1ns / 1ps

module uart_bootloader_host_sequencer_tb;
	import ubhs_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 5;
	localparam int SEGMENTS       = 8;
	localparam int SEG_ITEMS      = 32;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 4000;

	// Command codes that the block must ignore.
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	// Tracks the sequencer state and holds the result transactions still to arrive.
	class host_link_tracker;
		cfg_t        cfg;
		phase_t      ph;
		op_t         op;
		int unsigned send_idx;
		int unsigned tick_count;
		logic [31:0] target_addr;
		logic [7:0]  frame_sum;
		logic [7:0]  chunk_bytes [CHUNK_BYTES_DEF];
		int unsigned fill_count;
		bit          upload_ok;
		logic [15:0] id_shift;
		int unsigned id_left;
		bit          last_ignored;
		int unsigned mismatches;
		result_t     expected_replies [$];
		result_t     reply;
		bit          reply_valid;

		function new();
			cfg.ack_timeout_ticks = ACK_TIMEOUT_RST;
			cfg.id_timeout_ticks = ID_TIMEOUT_RST;
			cfg.flash_base_address = FLASH_BASE_RST;
			ph = PH_IDLE;
			op = OP_NONE;
			send_idx = 0;
			tick_count = 0;
			target_addr = FLASH_BASE_RST;
			frame_sum = '0;
			fill_count = 0;
			upload_ok = 0;
			id_shift = '0;
			id_left = 0;
			mismatches = 0;
		endfunction

		function void set_cfg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				CFG_ACK_TIMEOUT: cfg.ack_timeout_ticks = value[15:0];
				CFG_ID_TIMEOUT:  cfg.id_timeout_ticks = value[15:0];
				CFG_FLASH_BASE:  cfg.flash_base_address = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_replies.size();
		endfunction

		function bit is_ack_wait(phase_t p);
			case (p)
				PH_SYNC_ACK, PH_ID_ACK, PH_ID_END_ACK, PH_ER_ACK, PH_ER_END_ACK,
				PH_WR_ACK, PH_WR_ADDR_ACK, PH_WR_END_ACK: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function logic [2:0] fail_status(phase_t p);
			case (p)
				PH_SYNC_ACK:              return ST_SYNC_FAIL;
				PH_ID_ACK:                return ST_ID_ACK;
				PH_ID_COUNT:              return ST_ID_COUNT;
				PH_ID_BYTES:              return ST_ID_BYTES;
				PH_ID_END_ACK:            return ST_ID_END;
				PH_ER_ACK, PH_ER_END_ACK: return ST_ERASE_FAIL;
				default:                  return ST_WRITE_FAIL;
			endcase
		endfunction

		// A chunk write started by a full buffer has no operation, so it reports nothing.
		function void close_op(logic [2:0] status, logic [15:0] pid);
			if (status != ST_OK && op != OP_IDENT)
				upload_ok = 0;
			if (op != OP_NONE) begin
				reply_valid = 1;
				reply.done_res = 1'b1;
				reply.status = status;
				reply.product_id = (status == ST_OK && op == OP_IDENT) ? pid : 16'd0;
			end
			ph = PH_IDLE;
			op = OP_NONE;
		endfunction

		function void abort_op();
			if (ph >= PH_WR_TX0)
				fill_count = 0;
			close_op(fail_status(ph), '0);
		endfunction

		function void send_byte(logic [7:0] b, phase_t next);
			reply_valid = 1;
			reply.tx_valid = 1'b1;
			reply.tx_byte = b;
			tick_count = 0;
			ph = next;
		endfunction

		function void on_ack();
			case (ph)
				PH_SYNC_ACK: begin
					if (op == OP_IDENT)
						ph = PH_ID_TX0;
					else
						ph = PH_ER_TX0;
				end
				PH_ID_ACK: begin
					tick_count = 0;
					ph = PH_ID_COUNT;
				end
				PH_ID_END_ACK:  close_op(ST_OK, id_shift);
				PH_ER_ACK:      ph = PH_ER_ARG0;
				PH_ER_END_ACK:  close_op(ST_OK, '0);
				PH_WR_ACK: begin
					send_idx = 0;
					frame_sum = '0;
					ph = PH_WR_ADDR;
				end
				PH_WR_ADDR_ACK: ph = PH_WR_LEN;
				default: begin
					target_addr = target_addr + fill_count;
					fill_count = 0;
					close_op(ST_OK, '0);
				end
			endcase
		endfunction

		function void on_tick();
			logic [7:0] b;
			case (ph)
				PH_IDLE:    last_ignored = 1;
				PH_SYNC_TX: send_byte(BYTE_SYNC, PH_SYNC_ACK);
				PH_ID_TX0:  send_byte(BYTE_GET_ID, PH_ID_TX1);
				PH_ID_TX1:  send_byte(~BYTE_GET_ID, PH_ID_ACK);
				PH_ER_TX0:  send_byte(BYTE_ERASE, PH_ER_TX1);
				PH_ER_TX1:  send_byte(~BYTE_ERASE, PH_ER_ACK);
				PH_ER_ARG0: send_byte(BYTE_ERASE_GL, PH_ER_ARG1);
				PH_ER_ARG1: send_byte(BYTE_ZERO, PH_ER_END_ACK);
				PH_WR_TX0:  send_byte(BYTE_WRITE, PH_WR_TX1);
				PH_WR_TX1:  send_byte(~BYTE_WRITE, PH_WR_ACK);
				PH_WR_ADDR: begin
					// Address goes out most significant byte first.
					b = 8'(target_addr >> (24 - 8 * (send_idx % 4)));
					frame_sum ^= b;
					send_idx++;
					if (send_idx >= 4)
						send_byte(b, PH_WR_ASUM);
					else
						send_byte(b, PH_WR_ADDR);
				end
				PH_WR_ASUM: send_byte(frame_sum, PH_WR_ADDR_ACK);
				PH_WR_LEN: begin
					b = 8'(fill_count - 1);
					frame_sum = b;
					send_idx = 0;
					send_byte(b, PH_WR_DATA);
				end
				PH_WR_DATA: begin
					b = chunk_bytes[send_idx % CHUNK_BYTES_DEF];
					frame_sum ^= b;
					send_idx++;
					if (send_idx >= fill_count)
						send_byte(b, PH_WR_DSUM);
					else
						send_byte(b, PH_WR_DATA);
				end
				PH_WR_DSUM: send_byte(frame_sum, PH_WR_END_ACK);
				PH_ID_COUNT, PH_ID_BYTES: begin
					if (tick_count + 1 > cfg.id_timeout_ticks)
						abort_op();
					else
						tick_count++;
				end
				default: begin
					if (tick_count + 1 >= cfg.ack_timeout_ticks)
						abort_op();
					else
						tick_count++;
				end
			endcase
		endfunction

		function void on_target_byte(logic [7:0] b);
			if (is_ack_wait(ph)) begin
				if (b == BYTE_ACK)
					on_ack();
				else if (b == BYTE_NACK)
					abort_op();
				else
					last_ignored = 1;
			end else if (ph == PH_ID_COUNT) begin
				id_left = 32'(b) + 1;
				ph = PH_ID_BYTES;
			end else if (ph == PH_ID_BYTES) begin
				id_shift = {id_shift[7:0], b};
				id_left--;
				if (id_left == 0) begin
					tick_count = 0;
					ph = PH_ID_END_ACK;
				end
			end else begin
				last_ignored = 1;
			end
		endfunction

		// Notes one accepted input transaction and queues the result it causes, if any.
		function void predict_reply(logic [2:0] cmd, logic [7:0] d);
			reply = '0;
			reply_valid = 0;
			last_ignored = 0;
			if (cmd >= CMD_IDENTIFY && cmd <= CMD_UPLOAD_END && ph != PH_IDLE) begin
				reply_valid = 1;
				reply.rejected = 1'b1;
			end else begin
				case (cmd)
					CMD_TICK:        on_tick();
					CMD_TARGET_BYTE: on_target_byte(d);
					CMD_IDENTIFY: begin
						op = OP_IDENT;
						id_shift = '0;
						id_left = 0;
						ph = PH_SYNC_TX;
					end
					CMD_UPLOAD_START: begin
						op = OP_START;
						upload_ok = 1;
						target_addr = cfg.flash_base_address;
						fill_count = 0;
						ph = PH_SYNC_TX;
					end
					CMD_UPLOAD_DATA: begin
						if (upload_ok) begin
							chunk_bytes[fill_count % CHUNK_BYTES_DEF] = d;
							fill_count++;
							if (fill_count >= CHUNK_BYTES_DEF) begin
								op = OP_NONE;
								ph = PH_WR_TX0;
							end
						end else begin
							last_ignored = 1;
						end
					end
					CMD_UPLOAD_END: begin
						op = OP_END;
						if (upload_ok && fill_count > 0)
							ph = PH_WR_TX0;
						else
							close_op(upload_ok ? ST_OK : ST_WRITE_FAIL, '0);
					end
					default: last_ignored = 1;
				endcase
			end
			if (reply_valid)
				expected_replies.push_back(reply);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_reply(result_t got);
			result_t want;
			if (expected_replies.size() == 0) begin
				$error("result transaction with none outstanding: tx_byte %0h status %0h",
					got.tx_byte, got.status);
				mismatches++;
				return;
			end
			want = expected_replies.pop_front();
			compare_field("tx_valid", want.tx_valid, got.tx_valid);
			compare_field("tx_byte", want.tx_byte, got.tx_byte);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("status", want.status, got.status);
			compare_field("product_id", want.product_id, got.product_id);
			compare_field("rejected", want.rejected, got.rejected);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int unsigned items_counted = 0;
	int unsigned quiet_cycles = 0;

	host_link_tracker link = new();

	ubhs_item_if   item_ch ();
	ubhs_result_if result_ch ();

	uart_bootloader_host_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			link.check_reply({result_ch.tx_valid, result_ch.tx_byte, result_ch.done_res,
				result_ch.status, result_ch.product_id, result_ch.rejected});
	end

	// Ends the run when neither channel has moved a transaction for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("uart_bootloader_host_sequencer_tb: done, errors");
			$finish;
		end
	end

	// Chooses what the target or the host does next, from the phase the sequencer is in.
	function automatic void target_reply(output logic [2:0] c, output logic [7:0] d);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		c = CMD_TICK;
		d = 8'($urandom);
		if (link.is_ack_wait(link.ph)) begin
			if (roll < 80) begin
				c = CMD_TARGET_BYTE;
				d = BYTE_ACK;
			end else if (roll < 84) begin
				c = CMD_TARGET_BYTE;
				d = BYTE_NACK;
			end else if (roll < 90) begin
				// A stray byte must not be mistaken for a reply.
				c = CMD_TARGET_BYTE;
				if (d == BYTE_ACK || d == BYTE_NACK)
					d = BYTE_ZERO;
			end
		end else if (link.ph == PH_ID_COUNT) begin
			if (roll < 2) begin
				c = CMD_TARGET_BYTE;
				d = 8'hFF;
			end else if (roll < 85) begin
				c = CMD_TARGET_BYTE;
				d = 8'($urandom_range(0, 3));
			end
		end else if (link.ph == PH_ID_BYTES) begin
			if (roll < 85)
				c = CMD_TARGET_BYTE;
		end else if (roll < 4) begin
			c = 3'($urandom_range(CMD_IDENTIFY, CMD_UPLOAD_END));
		end else if (roll < 7) begin
			c = CMD_TARGET_BYTE;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] d);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.data <= d;
		do
			@(posedge clk);
		while (!item_ch.ready);
		link.predict_reply(cmd, d);
		if (!link.last_ignored)
			items_counted++;
		@(negedge clk);
	endtask

	task automatic settle_target();
		logic [2:0] c;
		logic [7:0] d;
		while (link.ph != PH_IDLE) begin
			target_reply(c, d);
			send_item(c, d);
		end
	endtask

	task automatic run_upload(input int unsigned nbytes);
		send_item(CMD_UPLOAD_START, 8'($urandom));
		settle_target();
		for (int unsigned i = 0; i < nbytes; i++) begin
			if (!link.upload_ok && $urandom_range(0, 3) != 0)
				break;
			send_item(CMD_UPLOAD_DATA, 8'($urandom));
			if (link.ph != PH_IDLE)
				settle_target();
		end
		send_item(CMD_UPLOAD_END, 8'($urandom));
		settle_target();
	endtask

	task automatic run_session();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			send_item(CMD_IDENTIFY, 8'($urandom));
			settle_target();
		end else if (roll < 80) begin
			if ($urandom_range(0, 19) == 0)
				run_upload($urandom_range(CHUNK_BYTES_DEF, CHUNK_BYTES_DEF + 40));
			else
				run_upload($urandom_range(1, 24));
		end else begin
			repeat ($urandom_range(3, 8))
				send_item(3'($urandom_range(0, 7)), 8'($urandom));
			settle_target();
		end
	endtask

	// Lets the last result drain, then leaves time for an item that causes none.
	task automatic wait_quiet();
		item_ch.valid <= 1'b0;
		while (link.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_settings(input logic [15:0] ack, input logic [15:0] idt,
		input logic [31:0] base);
		cfg_write <= 1'b1;
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= {16'd0, ack};
		@(negedge clk);
		cfg_index <= CFG_ID_TIMEOUT;
		cfg_data <= {16'd0, idt};
		@(negedge clk);
		cfg_index <= CFG_FLASH_BASE;
		cfg_data <= base;
		@(negedge clk);
		cfg_write <= 1'b0;
		link.set_cfg(CFG_ACK_TIMEOUT, {16'd0, ack});
		link.set_cfg(CFG_ID_TIMEOUT, {16'd0, idt});
		link.set_cfg(CFG_FLASH_BASE, base);
	endtask

	initial begin
		int unsigned seg_start;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_TICK;
		item_ch.data = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_ACK_TIMEOUT;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle block: ticks, target bytes, spare codes and data without an upload do nothing; upload end fails.
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TARGET_BYTE, 8'hFF);
		send_item(CMD_SPARE_HI, 8'hFF);
		send_item(CMD_SPARE_LO, 8'h00);
		send_item(CMD_UPLOAD_DATA, 8'hFF);
		send_item(CMD_UPLOAD_END, 8'h00);
		// A clean identify, with a command rejected while the final ACK is awaited.
		send_item(CMD_IDENTIFY, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TARGET_BYTE, BYTE_ACK);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TARGET_BYTE, BYTE_ACK);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TARGET_BYTE, 8'h01);
		send_item(CMD_TARGET_BYTE, 8'hA4);
		send_item(CMD_TARGET_BYTE, 8'h5B);
		send_item(CMD_UPLOAD_START, 8'h00);
		send_item(CMD_TARGET_BYTE, BYTE_ACK);
		// Upload start whose erase is refused after a stray byte.
		send_item(CMD_UPLOAD_START, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TARGET_BYTE, 8'h55);
		send_item(CMD_TARGET_BYTE, BYTE_ACK);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TARGET_BYTE, BYTE_NACK);
		wait_quiet();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 52; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 52; end
				default: begin src_idle_pct = 25; sink_stall_pct = 25; end
			endcase
			case (seg)
				1: load_settings(16'd1, 16'd1, 32'hFFFF_FFF0);
				2: load_settings(16'hFFFF, 16'hFFFF, 32'h0000_0000);
				3: load_settings(16'd3, 16'd2, $urandom);
				4, 5: load_settings(16'($urandom_range(2, 30)), 16'($urandom_range(1, 30)),
					$urandom);
				6: load_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
					$urandom);
				7: load_settings(ACK_TIMEOUT_RST, ID_TIMEOUT_RST, FLASH_BASE_RST);
				default: ;
			endcase
			seg_start = items_counted;
			// One upload large enough to fill the buffer and start a write on its own.
			if (seg == 0)
				run_upload(CHUNK_BYTES_DEF + 4);
			while (items_counted < seg_start + SEG_ITEMS)
				run_session();
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (link.mismatches == 0 && link.pending() == 0)
			$display("uart_bootloader_host_sequencer_tb: done, clean");
		else
			$display("uart_bootloader_host_sequencer_tb: done, errors");
		$finish;
	end

endmodule
